// ----- rtl/core/arphpc_pkg.sv -----
// Shared types, constants and codes for the ARP header parser/checker.
// No dependencies; every other file of the block imports this package.
package arphpc_pkg;

  localparam int unsigned HdrBytes = 28;
  localparam int unsigned HdrW     = HdrBytes * 8;
  localparam int unsigned PosW     = $clog2(HdrBytes);

  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_HW_TYPE    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PROTO_TYPE = 1'b1;

  localparam logic [15:0] EXP_HW_TYPE_RST    = 16'h0001;
  localparam logic [15:0] EXP_PROTO_TYPE_RST = 16'h0800;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HW    = 3'd2,
    ST_BAD_PROTO = 3'd3,
    ST_MCAST_MAC = 3'd4,
    ST_BAD_IP    = 3'd5
  } status_e;

  // One header record handed from the front end to the back end.
  // Byte 0 of the header sits in the top byte of hdr.
  typedef struct packed {
    logic            short_pkt;
    logic [HdrW-1:0] hdr;
  } arphpc_rec_t;

endpackage

// ----- rtl/core/arphpc_front.sv -----
// Front end: accepts packet bytes, counts header position, captures the header
// and pushes one record per packet. Depends on arphpc_pkg.
module arphpc_front import arphpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output arphpc_rec_t q_rec_o
);

  localparam logic [PosW-1:0] LastPos = PosW'(HdrBytes - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic            skip_q, skip_d;
  logic [HdrW-1:0] hdr_q, hdr_d;
  logic            accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hdr_d      = {hdr_q[HdrW-9:0], data_byte_i};

  always_comb begin
    pos_d    = pos_q;
    skip_d   = skip_q;
    q_push_o = 1'b0;
    q_rec_o  = '{short_pkt: 1'b0, hdr: hdr_d};
    if (accept) begin
      if (skip_q) begin
        // drop trailing bytes until the end of the packet
        if (last_byte_i) skip_d = 1'b0;
      end else if (pos_q == LastPos) begin
        q_push_o = 1'b1;
        pos_d    = '0;
        skip_d   = !last_byte_i;
      end else if (last_byte_i) begin
        q_push_o          = 1'b1;
        q_rec_o.short_pkt = 1'b1;
        pos_d             = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      skip_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      skip_q <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !skip_q) hdr_q <= hdr_d;
  end

endmodule

// ----- rtl/core/arphpc_queue.sv -----
// Short record queue between front and back end.
// Depends on arphpc_pkg for the record type.
module arphpc_queue import arphpc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  arphpc_rec_t rec_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output arphpc_rec_t rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  arphpc_rec_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntMax);
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= rec_i;
  end

endmodule

// ----- rtl/core/arphpc_back.sv -----
// Back end: holds the expected-type registers, runs the header checks on the
// queue head and keeps the verdict in the output register. Depends on arphpc_pkg.
module arphpc_back import arphpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                q_valid_i,
  input  arphpc_rec_t         q_rec_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [15:0]         hw_type_o,
  output logic [15:0]         proto_type_o,
  output logic [7:0]          hw_alen_o,
  output logic [7:0]          proto_addr_len_o,
  output logic [15:0]         opcode_o,
  output logic [47:0]         sender_mac_o,
  output logic [31:0]         sender_ip_o,
  output logic [47:0]         target_mac_o,
  output logic [31:0]         target_ip_o
);

  logic [15:0]     exp_hw_q, exp_proto_q;
  logic            out_valid_q;
  logic [HdrW-1:0] hdr;
  logic [HdrW-1:0] hdr_q;
  status_e         status_d, status_q;

  // short packets report all header fields as zero
  assign hdr = q_rec_i.short_pkt ? '0 : q_rec_i.hdr;

  always_comb begin
    if (q_rec_i.short_pkt)                                     status_d = ST_SHORT;
    else if (hdr[223:208] != exp_hw_q)                         status_d = ST_BAD_HW;
    else if (hdr[207:192] != exp_proto_q)                      status_d = ST_BAD_PROTO;
    else if (hdr[152])                                         status_d = ST_MCAST_MAC;
    else if (hdr[111:80] == '0 || hdr[111:80] == 32'hFFFF_FFFF) status_d = ST_BAD_IP;
    else                                                       status_d = ST_OK;
  end

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_hw_q    <= EXP_HW_TYPE_RST;
      exp_proto_q <= EXP_PROTO_TYPE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HW_TYPE:    exp_hw_q    <= cfg_wdata_i;
          CFG_PROTO_TYPE: exp_proto_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (q_pop_o)          out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      hdr_q    <= hdr;
      status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign hw_type_o        = hdr_q[223:208];
  assign proto_type_o     = hdr_q[207:192];
  assign hw_alen_o        = hdr_q[191:184];
  assign proto_addr_len_o = hdr_q[183:176];
  assign opcode_o         = hdr_q[175:160];
  assign sender_mac_o     = hdr_q[159:112];
  assign sender_ip_o      = hdr_q[111:80];
  assign target_mac_o     = hdr_q[79:32];
  assign target_ip_o      = hdr_q[31:0];

endmodule

// ----- rtl/core/arp_header_parse_check.sv -----
// ARP header parser/checker, top level.
// Instantiates arphpc_front, arphpc_queue and arphpc_back; uses arphpc_pkg.
//
// The block takes an ARP packet as one byte beat per clock, starting at the
// first header byte, with last_byte_i marking the final byte. It captures the
// 28 header bytes and delivers exactly one verdict beat per packet: at the
// 28th byte, or at an earlier last byte with status "short" and all fields
// zero. Checks, in priority order: short, hardware type, protocol type,
// multicast sender MAC, sender IP all zeros or all ones. Bytes after the
// header are dropped until the last byte. Throughput is one byte per clock
// while the queue is not full, with no gaps between packets; the front end's
// byte counter and header shift register take a byte every cycle unless
// stalled. Each verdict passes through the record queue and then into the
// output register. The queue (QueueDepth records) lets the input run on while
// a verdict waits on out_stall_i; the input stalls only when it is full.
// Write the expected types (index 0 hardware, index 1 protocol) only while no
// packet is in flight.
module arp_header_parse_check import arphpc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic [15:0]         hw_type_o,
  output logic [15:0]         proto_type_o,
  output logic [7:0]          hw_alen_o,
  output logic [7:0]          proto_addr_len_o,
  output logic [15:0]         opcode_o,
  output logic [47:0]         sender_mac_o,
  output logic [31:0]         sender_ip_o,
  output logic [47:0]         target_mac_o,
  output logic [31:0]         target_ip_o
);

  // record path between the parts
  logic        q_full, q_push, q_valid, q_pop;
  arphpc_rec_t push_rec, head_rec;

  // count bytes, shift in the header, push one record per packet
  arphpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_rec_o     (push_rec)
  );

  // decouple byte intake from verdict delivery
  arphpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  // check the header and hold the verdict beat
  arphpc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .q_valid_i        (q_valid),
    .q_rec_i          (head_rec),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .hw_type_o        (hw_type_o),
    .proto_type_o     (proto_type_o),
    .hw_alen_o        (hw_alen_o),
    .proto_addr_len_o (proto_addr_len_o),
    .opcode_o         (opcode_o),
    .sender_mac_o     (sender_mac_o),
    .sender_ip_o      (sender_ip_o),
    .target_mac_o     (target_mac_o),
    .target_ip_o      (target_ip_o)
  );

endmodule
